/* hdl/catmull_rom_path_sampler_unit_defines.svh */
// Assertion helpers for the sampler RTL.
`ifndef CATMULL_ROM_PATH_SAMPLER_UNIT_DEFINES_SVH
`define CATMULL_ROM_PATH_SAMPLER_UNIT_DEFINES_SVH

// Clocked check, off while reset is active.
`define CRPS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CRPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/crps_pkg.sv */
package crps_pkg;

	// anchors that weigh into one curve point
	localparam int NUM_TAPS = 4;

	// width of the sample index field on the result channel
	localparam int SAMPLE_INDEX_W = 3;

endpackage

/* hdl/crps_if.sv */
interface crps_point_if #(
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic                          restart;

	modport source (output valid, point_x, point_y, restart, input ready);
	modport sink   (input valid, point_x, point_y, restart, output ready);
endinterface

interface crps_sample_if #(
	parameter int COORD_WIDTH = 24
);
	logic                                    valid;
	logic                                    ready;
	logic signed [COORD_WIDTH-1:0]           curve_x;
	logic signed [COORD_WIDTH-1:0]           curve_y;
	logic [crps_pkg::SAMPLE_INDEX_W-1:0]     sample_index;
	logic                                    last_of_segment;

	modport source (output valid, curve_x, curve_y, sample_index, last_of_segment,
		input ready);
	modport sink   (input valid, curve_x, curve_y, sample_index, last_of_segment,
		output ready);
endinterface

/* hdl/crps_lane.sv */
// One tap lane: scale the x and y of one anchor by the basis weight of the
// current sample.
module crps_lane #(
	parameter int CW = 24,
	parameter int WW = 17
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [CW-1:0]     anchor_x,
	input  logic signed [CW-1:0]     anchor_y,
	input  logic signed [WW-1:0]     weight,
	output logic signed [CW+WW-1:0]  prod_x_s1,
	output logic signed [CW+WW-1:0]  prod_y_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= (CW+WW)'(anchor_x) * (CW+WW)'(weight);
			prod_y_s1 <= (CW+WW)'(anchor_y) * (CW+WW)'(weight);
		end
	end

endmodule

/* hdl/crps_merge.sv */
// Merge the tap products of one axis: sum, round half up, saturate.
module crps_merge #(
	parameter int CW  = 24,
	parameter int WW  = 17,
	parameter int WFB = 15
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [CW+WW-1:0]  prod [crps_pkg::NUM_TAPS],
	output logic signed [CW-1:0]     result_s2
);

	localparam int AW = CW + WW + 2;
	localparam logic signed [AW-1:0] Half = AW'(1) <<< (WFB - 1);
	localparam logic signed [CW-1:0] MaxV = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MinV = {1'b1, {(CW-1){1'b0}}};

	logic signed [AW-1:0] sum;
	logic signed [AW-1:0] rnd;
	logic                 in_range;
	logic signed [CW-1:0] sat;

	always_comb begin
		sum = Half;
		for (int i = 0; i < crps_pkg::NUM_TAPS; i++) begin
			sum = sum + AW'(prod[i]);
		end
		rnd = sum >>> WFB;
		// in range when every bit above the coordinate sign matches it
		in_range = (&rnd[AW-1:CW-1]) || !(|rnd[AW-1:CW-1]);
		if (in_range) begin
			sat = rnd[CW-1:0];
		end else if (rnd[AW-1]) begin
			sat = MinV;
		end else begin
			sat = MaxV;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s2 <= sat;
		end
	end

endmodule

/* hdl/catmull_rom_path_sampler_unit.sv */
// Uniform Catmull-Rom path sampler. Anchors arrive on the anchor channel;
// the block holds the last three of the current path, and from the fourth
// anchor on each anchor closes the segment between the two middle ones and
// yields STEPS+1 samples at t = k/STEPS, one per cycle while the output does
// not stall, on the sample channel. A raised restart flag starts a new path
// with that anchor. An anchor that closes a segment occupies the sample
// sequencer until its final sample is issued, and the next anchor is taken
// in the cycle that issues the final sample; anchors that close no segment
// leave the sequencer free. Four tap lanes multiply both axes in parallel,
// and a merge stage sums, rounds and saturates; a sample is registered in
// the lanes and then in the merge stage before it appears. Output
// backpressure stalls the whole pipeline.
`include "catmull_rom_path_sampler_unit_defines.svh"

module catmull_rom_path_sampler_unit #(
	parameter int STEPS            = 5,
	parameter int COORD_WIDTH      = 24,
	parameter int WEIGHT_FRAC_BITS = 15
) (
	input logic            clk,
	input logic            arst_n,
	crps_point_if.sink     anchor,
	crps_sample_if.source  sample
);

	localparam int KW = $clog2(STEPS + 1);
	localparam int WW = WEIGHT_FRAC_BITS + 2;
	localparam int PW = COORD_WIDTH + WW;
	localparam int NT = crps_pkg::NUM_TAPS;
	localparam longint DEN = 2 * STEPS * STEPS * STEPS;
	localparam logic [KW-1:0] KLast = KW'(STEPS);

	// basis weight of tap i at sample k, rounded half away from zero
	function automatic longint weight_val(input int i, input longint k);
		longint s;
		longint n;
		longint m;
		longint mag;
		s = STEPS;
		case (i)
			0: begin
				n = -k * s * s + 2 * k * k * s - k * k * k;
			end
			1: begin
				n = 2 * s * s * s - 5 * k * k * s + 3 * k * k * k;
			end
			2: begin
				n = k * s * s + 4 * k * k * s - 3 * k * k * k;
			end
			default: begin
				n = -k * k * s + k * k * k;
			end
		endcase
		m = (n < 0) ? -n : n;
		mag = ((m <<< WEIGHT_FRAC_BITS) + DEN / 2) / DEN;
		return (n < 0) ? -mag : mag;
	endfunction

	logic signed [WW-1:0] wtab [STEPS+1][NT];

	for (genvar gk = 0; gk <= STEPS; gk++) begin : g_wrow
		for (genvar gi = 0; gi < NT; gi++) begin : g_wcol
			assign wtab[gk][gi] = WW'(weight_val(gi, gk));
		end
	end

	// anchor window, oldest first
	logic signed [COORD_WIDTH-1:0] win_x_q [3];
	logic signed [COORD_WIDTH-1:0] win_y_q [3];
	logic [1:0]                    held_q;

	// segment being sampled
	logic signed [COORD_WIDTH-1:0] seg_x_q [NT];
	logic signed [COORD_WIDTH-1:0] seg_y_q [NT];
	logic                          busy_q;
	logic [KW-1:0]                 k_q;

	logic          v_s1;
	logic [KW-1:0] k_s1;
	logic          v_s2;
	logic [KW-1:0] k_s2;

	logic       advance;
	logic       issue;
	logic       acc;
	logic [1:0] held_eff;
	logic       full_new;

	assign advance  = !v_s2 || sample.ready;
	assign issue    = busy_q && advance;
	assign anchor.ready = !busy_q || (issue && (k_q == KLast));
	assign acc      = anchor.valid && anchor.ready;
	assign held_eff = anchor.restart ? 2'd0 : held_q;
	assign full_new = acc && (held_eff == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
		end else if (acc && (held_eff != 2'd3)) begin
			held_q <= held_eff + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (held_eff != 2'd3) begin
				win_x_q[held_eff] <= anchor.point_x;
				win_y_q[held_eff] <= anchor.point_y;
			end else begin
				// drop the oldest, append the new anchor
				win_x_q[0] <= win_x_q[1];
				win_x_q[1] <= win_x_q[2];
				win_x_q[2] <= anchor.point_x;
				win_y_q[0] <= win_y_q[1];
				win_y_q[1] <= win_y_q[2];
				win_y_q[2] <= anchor.point_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (full_new) begin
			for (int i = 0; i < 3; i++) begin
				seg_x_q[i] <= win_x_q[i];
				seg_y_q[i] <= win_y_q[i];
			end
			seg_x_q[NT-1] <= anchor.point_x;
			seg_y_q[NT-1] <= anchor.point_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (full_new) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (issue) begin
			if (k_q == KLast) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			k_s1 <= k_q;
			k_s2 <= k_s1;
		end
	end

	logic signed [PW-1:0] prod_x_s1 [NT];
	logic signed [PW-1:0] prod_y_s1 [NT];

	for (genvar gi = 0; gi < NT; gi++) begin : g_lane
		crps_lane #(
			.CW (COORD_WIDTH),
			.WW (WW)
		) u_lane (
			.clk       (clk),
			.en        (advance),
			.anchor_x  (seg_x_q[gi]),
			.anchor_y  (seg_y_q[gi]),
			.weight    (wtab[k_q][gi]),
			.prod_x_s1 (prod_x_s1[gi]),
			.prod_y_s1 (prod_y_s1[gi])
		);
	end

	logic signed [COORD_WIDTH-1:0] curve_x_s2;
	logic signed [COORD_WIDTH-1:0] curve_y_s2;

	crps_merge #(
		.CW  (COORD_WIDTH),
		.WW  (WW),
		.WFB (WEIGHT_FRAC_BITS)
	) u_merge_x (
		.clk       (clk),
		.en        (advance),
		.prod      (prod_x_s1),
		.result_s2 (curve_x_s2)
	);

	crps_merge #(
		.CW  (COORD_WIDTH),
		.WW  (WW),
		.WFB (WEIGHT_FRAC_BITS)
	) u_merge_y (
		.clk       (clk),
		.en        (advance),
		.prod      (prod_y_s1),
		.result_s2 (curve_y_s2)
	);

	assign sample.valid           = v_s2;
	assign sample.curve_x         = curve_x_s2;
	assign sample.curve_y         = curve_y_s2;
	assign sample.sample_index    = crps_pkg::SAMPLE_INDEX_W'(k_s2);
	assign sample.last_of_segment = (k_s2 == KLast);

	`CRPS_ASSERT(a_take_only_on_last, clk, arst_n, acc && busy_q |-> issue && (k_q == KLast), "anchor taken mid-segment")
	`CRPS_ASSERT(a_segment_starts, clk, arst_n, full_new |=> busy_q && (k_q == '0), "segment did not start at k zero")
	`CRPS_ASSERT(a_stall_holds_s1, clk, arst_n, v_s1 && !advance |=> v_s1 && $stable(k_s1), "inner stage lost a sample under stall")
	`CRPS_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !busy_q && !v_s1 && !v_s2, "pipeline not idle in reset")

endmodule

/* test/catmull_rom_path_sampler_unit_tb.sv */
`timescale 1ns / 100ps

module catmull_rom_path_sampler_unit_tb;

	localparam int STEPS      = 5;
	localparam int COORD_W    = 24;
	localparam int WFRAC      = 15;
	localparam int IDX_W      = crps_pkg::SAMPLE_INDEX_W;
	localparam int WATCH_LIMIT = 2000;
	localparam int RANDOM_ANCHORS = 250;

	localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [IDX_W-1:0]          idx;
		logic                      last;
	} curve_pt_t;

	// ends_known: the first and last sample equal P1 and P2 of the segment
	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		bit                        restart;
		bit                        ends_known;
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
	} anchor_row_t;

	logic clk;
	logic arst_n;

	crps_point_if  #(.COORD_WIDTH(COORD_W)) anchor_ch ();
	crps_sample_if #(.COORD_WIDTH(COORD_W)) sample_ch ();

	catmull_rom_path_sampler_unit #(
		.STEPS(STEPS),
		.COORD_WIDTH(COORD_W),
		.WEIGHT_FRAC_BITS(WFRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.anchor(anchor_ch),
		.sample(sample_ch)
	);

	anchor_row_t directed_rows [22] = '{
		'{24'sd0, 24'sd0, 1'b0, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{C_MAX, C_MIN, 1'b0, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{C_MIN, C_MAX, 1'b0, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{C_MAX, C_MIN, 1'b0, 1'b1, C_MAX, C_MIN, C_MIN, C_MAX},
		'{C_MIN, C_MAX, 1'b0, 1'b1, C_MIN, C_MAX, C_MAX, C_MIN},
		'{24'sd0, 24'sd0, 1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{24'sd1, -24'sd1, 1'b0, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{-24'sd1, 24'sd1, 1'b0, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{24'sd2, -24'sd2, 1'b0, 1'b1, 24'sd1, -24'sd1, -24'sd1, 24'sd1},
		'{C_MAX, C_MAX, 1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{C_MAX, C_MAX, 1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{C_MAX, C_MAX, 1'b0, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{C_MAX, C_MAX, 1'b0, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{C_MAX, C_MAX, 1'b0, 1'b1, C_MAX, C_MAX, C_MAX, C_MAX},
		'{C_MIN, C_MIN, 1'b0, 1'b1, C_MAX, C_MAX, C_MAX, C_MAX},
		'{C_MIN, C_MIN, 1'b1, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{C_MIN, C_MIN, 1'b0, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{C_MIN, C_MIN, 1'b0, 1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
		'{C_MIN, C_MIN, 1'b0, 1'b1, C_MIN, C_MIN, C_MIN, C_MIN},
		'{C_MAX, C_MAX, 1'b0, 1'b1, C_MIN, C_MIN, C_MIN, C_MIN},
		'{24'sh555555, 24'shaaaaaa, 1'b0, 1'b1, C_MIN, C_MIN, C_MAX, C_MAX},
		'{24'shaaaaaa, 24'sh555555, 1'b0, 1'b1, C_MAX, C_MAX, 24'sh555555, 24'shaaaaaa}
	};

	// Predictor state: held anchors, oldest first
	logic signed [COORD_W-1:0] win_x [3];
	logic signed [COORD_W-1:0] win_y [3];
	int                        anchors_held;

	curve_pt_t pending_pts [$];
	curve_pt_t want_pt;
	int        fail_count;
	int        idle_cycles;
	int        burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// Basis weight i at t = k/STEPS, scaled by 2^WFRAC, rounded half away from zero
	function automatic longint basis_weight(input int i, input int k);
		longint s   = STEPS;
		longint kk  = k;
		longint den = 2 * STEPS * STEPS * STEPS;
		longint n;
		longint m;
		case (i)
			0:       n = -kk * s * s + 2 * kk * kk * s - kk * kk * kk;
			1:       n = 2 * s * s * s - 5 * kk * kk * s + 3 * kk * kk * kk;
			2:       n = kk * s * s + 4 * kk * kk * s - 3 * kk * kk * kk;
			default: n = -kk * kk * s + kk * kk * kk;
		endcase
		m = (n < 0) ? -n : n;
		m = ((m <<< WFRAC) + den / 2) / den;
		return (n < 0) ? -m : m;
	endfunction

	function automatic logic signed [COORD_W-1:0] blend_axis(
		input logic signed [COORD_W-1:0] p0, p1, p2, p3, input int k);
		longint acc;
		acc = longint'(p0) * basis_weight(0, k) + longint'(p1) * basis_weight(1, k)
			+ longint'(p2) * basis_weight(2, k) + longint'(p3) * basis_weight(3, k);
		acc = (acc + (longint'(1) <<< (WFRAC - 1))) >>> WFRAC;
		if (acc > longint'(C_MAX))
			return C_MAX;
		if (acc < longint'(C_MIN))
			return C_MIN;
		return acc[COORD_W-1:0];
	endfunction

	// Advance the anchor window and queue the samples this anchor yields
	task automatic sample_segment(input logic signed [COORD_W-1:0] nx, ny,
		input bit restart, output int produced);
		curve_pt_t pt;
		produced = 0;
		if (restart)
			anchors_held = 0;
		if (anchors_held < 3) begin
			win_x[anchors_held] = nx;
			win_y[anchors_held] = ny;
			anchors_held++;
			return;
		end
		for (int k = 0; k <= STEPS; k++) begin
			pt.x    = blend_axis(win_x[0], win_x[1], win_x[2], nx, k);
			pt.y    = blend_axis(win_y[0], win_y[1], win_y[2], ny, k);
			pt.idx  = k[IDX_W-1:0];
			pt.last = (k == STEPS);
			pending_pts = {pending_pts, pt};
			produced++;
		end
		win_x[0] = win_x[1];
		win_x[1] = win_x[2];
		win_x[2] = nx;
		win_y[0] = win_y[1];
		win_y[1] = win_y[2];
		win_y[2] = ny;
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			anchor_ch.valid   = 1'b0;
			anchor_ch.point_x = COORD_W'($urandom);
			anchor_ch.point_y = COORD_W'($urandom);
			anchor_ch.restart = 1'($urandom_range(0, 1));
		end
	endtask

	task automatic send_anchor(input logic signed [COORD_W-1:0] x, y, input bit restart,
		input bit ends_known = 1'b0,
		input logic signed [COORD_W-1:0] x0 = '0, y0 = '0, x1 = '0, y1 = '0);
		int        produced;
		int        head;
		curve_pt_t pt;
		@(negedge clk);
		anchor_ch.valid   = 1'b1;
		anchor_ch.point_x = x;
		anchor_ch.point_y = y;
		anchor_ch.restart = restart;
		do
			@(posedge clk);
		while (!anchor_ch.ready);
		sample_segment(x, y, restart, produced);
		if (ends_known && produced > 0) begin
			// pin the endpoints to the values read off the segment's middle anchors
			head = pending_pts.size() - 1 - STEPS;
			pt = pending_pts[head];
			pt.x = x0;
			pt.y = y0;
			pending_pts[head] = pt;
			pt = pending_pts[head + STEPS];
			pt.x = x1;
			pt.y = y1;
			pending_pts[head + STEPS] = pt;
		end
	endtask

	// Bursts of random length, mostly with random gaps between them
	task automatic pace_sender();
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 8));
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		anchor_ch.valid = 1'b0;
		while (pending_pts.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] pick_coord();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return COORD_W'($urandom);
			5, 6: begin
				v = $urandom_range(0, 8191);
				return COORD_W'(v - 4096);
			end
			7: return C_MAX;
			8: return C_MIN;
			default: return {($urandom_range(0, 1) ? 2'b01 : 2'b10), 22'($urandom)};
		endcase
	endfunction

	initial begin : stimulus
		int  sent;
		int  n;
		int  roll;
		bit  mid_drained;
		fail_count   = 0;
		anchors_held = 0;
		burst_left   = 0;
		mid_drained  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			win_x[i] = '0;
			win_y[i] = '0;
		end
		anchor_ch.valid   = 1'b0;
		anchor_ch.point_x = '0;
		anchor_ch.point_y = '0;
		anchor_ch.restart = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			send_anchor(directed_rows[i].x, directed_rows[i].y, directed_rows[i].restart,
				directed_rows[i].ends_known, directed_rows[i].x0, directed_rows[i].y0,
				directed_rows[i].x1, directed_rows[i].y1);
			pace_sender();
		end
		hold_until_drained();

		sent = 0;
		while (sent < RANDOM_ANCHORS) begin
			if (!mid_drained && sent >= RANDOM_ANCHORS / 2) begin
				hold_until_drained();
				mid_drained = 1'b1;
			end
			roll = $urandom_range(0, 19);
			if (roll == 0) begin
				// broken paths: a few anchors that each start over
				n = $urandom_range(1, 3);
				repeat (n) begin
					send_anchor(pick_coord(), pick_coord(), 1'b1);
					pace_sender();
					sent++;
				end
			end else begin
				send_anchor(pick_coord(), pick_coord(), roll == 1);
				pace_sender();
				sent++;
			end
		end

		@(negedge clk);
		anchor_ch.valid = 1'b0;
		while (pending_pts.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Receiver: switches at random between always ready, random ready and a rotating ready pattern
	initial begin : receiver
		int         mode;
		int         left;
		logic [15:0] pat;
		sample_ch.ready = 1'b0;
		mode = 0;
		left = 0;
		pat  = 16'hffff;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(20, 80);
				pat  = 16'($urandom) | 16'h0001;
			end
			left--;
			case (mode)
				0: sample_ch.ready = 1'b1;
				1: sample_ch.ready = 1'($urandom_range(0, 1));
				default: begin
					sample_ch.ready = pat[0];
					pat = {pat[0], pat[15:1]};
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			if (pending_pts.size() == 0) begin
				report_mismatch("sample with nothing pending, index",
					longint'(sample_ch.sample_index), -1);
			end else begin
				want_pt = pending_pts.pop_front();
				if (sample_ch.curve_x !== want_pt.x)
					report_mismatch("curve_x", longint'(sample_ch.curve_x),
						longint'(want_pt.x));
				if (sample_ch.curve_y !== want_pt.y)
					report_mismatch("curve_y", longint'(sample_ch.curve_y),
						longint'(want_pt.y));
				if (sample_ch.sample_index !== want_pt.idx)
					report_mismatch("sample_index", longint'(sample_ch.sample_index),
						longint'(want_pt.idx));
				if (sample_ch.last_of_segment !== want_pt.last)
					report_mismatch("last_of_segment", longint'(sample_ch.last_of_segment),
						longint'(want_pt.last));
			end
		end
	end

	// Watchdog: cycles without any transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (anchor_ch.valid && anchor_ch.ready)
				|| (sample_ch.valid && sample_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCH_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

/* catmull_rom_path_sampler_unit.f */
+incdir+hdl
hdl/crps_pkg.sv
hdl/crps_if.sv
hdl/crps_lane.sv
hdl/crps_merge.sv
hdl/catmull_rom_path_sampler_unit.sv
test/catmull_rom_path_sampler_unit_tb.sv
